[src/lodc_pkg.sv]
`timescale 1ns / 1ps

package lodc_pkg;

    localparam int NUM_LOCKS_DEF   = 32;
    localparam int STACK_DEPTH_DEF = 16;

    // Fixed field widths of the event and result beats.
    localparam int ID_W     = 5;
    localparam int STATUS_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_BAD_UNLOCK = 3'd1,
        STAT_DEADLOCK   = 3'd2,
        STAT_STACK_FULL = 3'd3,
        STAT_HALTED     = 3'd4
    } lodc_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_EDGE,
        S_PICK,
        S_EXPAND,
        S_OUT
    } lodc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic         latch;
        logic         row_rd_top;
        logic         edge_wr;
        logic         walk_pick;
        logic         walk_expand;
        logic         push;
        logic         pop;
        logic         halt;
        logic         res_set;
        lodc_status_t res_status;
        logic         res_fresh;
        logic         out_load;
    } lodc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic halted;
        logic in_range;
        logic is_release;
        logic empty;
        logic full;
        logic top_match;
        logic edge_known;
        logic pending_empty;
        logic target_hit;
        logic out_free;
    } lodc_sts_t;

endpackage

[src/lodc_ctrl.sv]
`timescale 1ns / 1ps

module lodc_ctrl
    import lodc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  lodc_sts_t sts,
    output lodc_cmd_t cmd
);

    lodc_state_t state_reg;
    lodc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                priority if (sts.halted || !sts.in_range || sts.is_release || sts.full
                             || sts.empty || sts.top_match)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_EDGE;
                end
            end
            S_EDGE:
            begin
                state_next = sts.edge_known ? S_OUT : S_PICK;
            end
            S_PICK:
            begin
                state_next = sts.pending_empty ? S_OUT : S_EXPAND;
            end
            S_EXPAND:
            begin
                state_next = sts.target_hit ? S_OUT : S_PICK;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.res_status = STAT_OK;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            S_DECIDE:
            begin
                priority if (sts.halted)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STAT_HALTED;
                end
                else if (!sts.in_range)
                begin
                    cmd.res_set = 1'b1;
                end
                else if (sts.is_release)
                begin
                    cmd.res_set = 1'b1;
                    if (sts.empty || !sts.top_match)
                    begin
                        cmd.res_status = STAT_BAD_UNLOCK;
                        cmd.halt       = 1'b1;
                    end
                    else
                    begin
                        cmd.pop = 1'b1;
                    end
                end
                else if (sts.full)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STAT_STACK_FULL;
                    cmd.halt       = 1'b1;
                end
                else if (sts.empty || sts.top_match)
                begin
                    // Nothing held, or a recursive acquire of the top lock.
                    cmd.res_set = 1'b1;
                    cmd.push    = 1'b1;
                end
                else
                begin
                    cmd.row_rd_top = 1'b1;
                end
            end
            S_EDGE:
            begin
                if (sts.edge_known)
                begin
                    cmd.res_set = 1'b1;
                    cmd.push    = 1'b1;
                end
                else
                begin
                    cmd.edge_wr = 1'b1;
                end
            end
            S_PICK:
            begin
                if (sts.pending_empty)
                begin
                    cmd.res_set   = 1'b1;
                    cmd.res_fresh = 1'b1;
                    cmd.push      = 1'b1;
                end
                else
                begin
                    cmd.walk_pick = 1'b1;
                end
            end
            S_EXPAND:
            begin
                cmd.walk_expand = 1'b1;
                if (sts.target_hit)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_fresh  = 1'b1;
                    cmd.res_status = STAT_DEADLOCK;
                    cmd.halt       = 1'b1;
                end
            end
            S_OUT:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

[src/lodc_dp.sv]
`timescale 1ns / 1ps

module lodc_dp
    import lodc_pkg::*;
#(
    parameter int NUM_LOCKS   = NUM_LOCKS_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_op,
    input  logic [ID_W-1:0]     in_id,
    input  lodc_cmd_t           cmd,
    output lodc_sts_t           sts,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] out_status,
    output logic                out_fresh,
    output logic [ID_W-1:0]     out_from,
    output logic [ID_W-1:0]     out_to
);

    localparam int LW = $clog2(NUM_LOCKS);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Order graph: row a holds the successors of lock a.
    logic [NUM_LOCKS-1:0] graph_mem [NUM_LOCKS];
    logic [ID_W-1:0]      stack_mem [STACK_DEPTH];

    logic [NUM_LOCKS-1:0] row_valid_reg;
    logic                 row_valid_rd_reg;
    logic [NUM_LOCKS-1:0] row_rd_reg;
    logic [ID_W-1:0]      stack_rd_reg;

    logic                 op_reg;
    logic [ID_W-1:0]      id_reg;
    logic [CW-1:0]        count_reg;
    logic                 halted_reg;
    logic [NUM_LOCKS-1:0] seen_reg;
    logic [NUM_LOCKS-1:0] pending_reg;

    lodc_status_t         res_status_reg;
    logic                 res_fresh_reg;
    logic [ID_W-1:0]      res_from_reg;
    logic [ID_W-1:0]      res_to_reg;

    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic                 out_fresh_reg;
    logic [ID_W-1:0]      out_from_reg;
    logic [ID_W-1:0]      out_to_reg;

    logic [LW-1:0]        id_idx;
    logic [LW-1:0]        top_idx;
    logic [LW-1:0]        pick_idx;
    logic [LW-1:0]        rd_addr;
    logic [SW-1:0]        stack_addr;
    logic [SW-1:0]        push_addr;
    logic [NUM_LOCKS-1:0] row_eff;
    logic [NUM_LOCKS-1:0] id_bit;
    logic [NUM_LOCKS-1:0] pick_bit;
    logic                 empty;
    logic                 out_free;

    function automatic logic [LW-1:0] first_set(input logic [NUM_LOCKS-1:0] v);
        logic [LW-1:0] idx;
        idx = '0;
        for (int i = NUM_LOCKS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = LW'(i);
            end
        end
        return idx;
    endfunction

    assign id_idx     = LW'(id_reg);
    assign top_idx    = LW'(stack_rd_reg);
    assign pick_idx   = first_set(pending_reg);
    assign rd_addr    = cmd.row_rd_top ? top_idx : pick_idx;
    assign empty      = (count_reg == '0);
    assign stack_addr = empty ? '0 : SW'(count_reg - CW'(1));
    assign push_addr  = SW'(count_reg);
    // A row that was never written reads as no edges.
    assign row_eff    = row_valid_rd_reg ? row_rd_reg : '0;
    assign id_bit     = {{(NUM_LOCKS-1){1'b0}}, 1'b1} << id_idx;
    assign pick_bit   = {{(NUM_LOCKS-1){1'b0}}, 1'b1} << pick_idx;
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        sts.halted        = halted_reg;
        sts.in_range      = int'(id_reg) < NUM_LOCKS;
        sts.is_release    = op_reg;
        sts.empty         = empty;
        sts.full          = (count_reg >= CW'(STACK_DEPTH));
        sts.top_match     = (stack_rd_reg == id_reg);
        sts.edge_known    = row_eff[id_idx];
        sts.pending_empty = (pending_reg == '0);
        sts.target_hit    = row_eff[top_idx];
        sts.out_free      = out_free;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.edge_wr)
        begin
            graph_mem[top_idx] <= row_eff | id_bit;
        end
        row_rd_reg <= graph_mem[rd_addr];
        if (cmd.push)
        begin
            stack_mem[push_addr] <= id_reg;
        end
        stack_rd_reg <= stack_mem[stack_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg    <= '0;
            row_valid_rd_reg <= 1'b0;
            count_reg        <= '0;
            halted_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            row_valid_rd_reg <= row_valid_reg[rd_addr];
            if (cmd.edge_wr)
            begin
                row_valid_reg[top_idx] <= 1'b1;
            end
            if (cmd.push)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.pop)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.halt)
            begin
                halted_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg <= in_op;
            id_reg <= in_id;
        end
        // The walk starts at the new lock and looks for the top lock.
        if (cmd.edge_wr)
        begin
            seen_reg    <= id_bit;
            pending_reg <= id_bit;
        end
        else if (cmd.walk_pick)
        begin
            pending_reg <= pending_reg & ~pick_bit;
        end
        else if (cmd.walk_expand)
        begin
            seen_reg    <= seen_reg | row_eff;
            pending_reg <= pending_reg | (row_eff & ~seen_reg);
        end
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_status;
            res_fresh_reg  <= cmd.res_fresh;
            res_from_reg   <= cmd.res_fresh ? stack_rd_reg : '0;
            res_to_reg     <= cmd.res_fresh ? id_reg : '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_fresh_reg  <= res_fresh_reg;
            out_from_reg   <= res_from_reg;
            out_to_reg     <= res_to_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_fresh  = out_fresh_reg;
    assign out_from   = out_from_reg;
    assign out_to     = out_to_reg;

endmodule

[src/lock_order_deadlock_checker.sv]
`timescale 1ns / 1ps

// Channel  Direction  tdata (low bit up)                tuser (low bit up)
// s_*      in         lock_id[4:0], 3 zero bits         opcode
// m_*      out        edge_from[4:0], edge_to[4:0],     status[2:0], new_edge
//                     6 zero bits
//
// One event at a time: halted, out of range, release and simple acquire events
// pass IDLE, DECIDE and OUT, an acquire along a known edge adds EDGE, and one that
// adds an edge then steps PICK and EXPAND once per lock the reachability walk
// expands (ending in EXPAND on a deadlock), as the graph memory has one read port.
// Reset clears the graph through per-row valid bits, so no clearing pass runs.
// A stalled result holds in the output register while the next event is accepted
// and worked; that event's result waits for the register to drain.

module lock_order_deadlock_checker
    import lodc_pkg::*;
#(
    parameter int NUM_LOCKS   = NUM_LOCKS_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // lock_id[4:0], zero fill
    input  logic [0:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // edge_from[4:0], edge_to[9:5], zero fill
    output logic [3:0]  m_tuser    // status[2:0], new_edge[3]
);

    lodc_cmd_t           cmd;
    lodc_sts_t           sts;
    logic [STATUS_W-1:0] out_status;
    logic                out_fresh;
    logic [ID_W-1:0]     out_from;
    logic [ID_W-1:0]     out_to;

    lodc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lodc_dp #(
        .NUM_LOCKS   (NUM_LOCKS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_op      (s_tuser[0]),
        .in_id      (s_tdata[ID_W-1:0]),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_fresh  (out_fresh),
        .out_from   (out_from),
        .out_to     (out_to)
    );

    assign m_tdata = {6'b0, out_to, out_from};
    assign m_tuser = {out_fresh, out_status};

endmodule
